FILE: hw/rtl/mi4_pkg.sv
// Shared types, widths and helpers for the 4x4 matrix inverse block.
// Used by the datapath and the top level; no dependencies.
package mi4_pkg;

  localparam int unsigned ElemW = 32;
  localparam int unsigned CofW  = 97;
  localparam int unsigned DetW  = 131;

  localparam logic [ElemW-1:0] QMax = 32'h7FFF_FFFF;
  localparam logic [ElemW-1:0] QMin = 32'h8000_0000;

  typedef enum logic [2:0] {
    DpIdle  = 3'd0,
    DpLdMul = 3'd1,
    DpMul   = 3'd2,
    DpAbs   = 3'd3,
    DpSing  = 3'd4,
    DpLdDiv = 3'd5,
    DpNeg   = 3'd6,
    DpDiv   = 3'd7
  } dp_op_e;

  typedef enum logic [1:0] {
    ASelElem = 2'd0,
    ASelTacc = 2'd1,
    ASelCof  = 2'd2
  } asel_e;

  typedef struct packed {
    dp_op_e op;
    asel_e  a_sel;
    logic   tgt_c;
    logic   clr;
    logic   neg;
    logic   last;
    logic   first;
  } dp_ctrl_t;

  typedef struct packed {
    logic sing;
    logic big;
  } dp_stat_t;

  // Address of element (k, n) of the 3x3 minor that leaves out row r and column c.
  function automatic logic [3:0] minor_addr(input logic [1:0] r, input logic [1:0] c,
                                            input logic [1:0] k, input logic [1:0] n);
    logic [1:0] row;
    logic [1:0] col;
    row = (k < r) ? k : k + 2'd1;
    col = (n < c) ? n : n + 2'd1;
    return {row, col};
  endfunction

endpackage

FILE: hw/rtl/mi4_ram.sv
// Small synchronous RAM with one write port and one registered read port.
// Depends on nothing; used for the matrix and cofactor stores.
module mi4_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hw/rtl/mi4_dp.sv
// Wide datapath around one shared adder: shift-add multiply, negate,
// compare and restoring divide steps. Depends on mi4_pkg.
module mi4_dp import mi4_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic             clk_i,
  input  dp_ctrl_t         ctrl_i,
  input  logic [30:0]      thr_i,
  input  logic [ElemW-1:0] elem_a_i,
  input  logic [ElemW-1:0] elem_b_i,
  input  logic [CofW-1:0]  cof_i,
  output logic [CofW-1:0]  cof_o,
  output dp_stat_t         stat_o,
  output logic [ElemW-1:0] value_o,
  output logic             sat_o
);

  localparam int unsigned NumW = CofW + 2 * FRAC_BITS + 1;
  localparam int unsigned DivW = DetW + ElemW + 1;
  localparam int unsigned WW   = ((NumW > DivW) ? NumW : DivW) + 1;

  logic [WW-1:0]    a_q, t_q, c_q;
  logic [ElemW-1:0] b_q, q_q;
  logic             det_neg_q, num_neg_q, big_q;

  logic [WW-1:0] x, y, sum, thr_sh, elem_ext, cof_ext, a_ld;
  logic          inv, sum_neg, neg;

  assign thr_sh   = {{(WW-31){1'b0}}, thr_i} << (3 * FRAC_BITS);
  assign elem_ext = {{(WW-ElemW){elem_a_i[ElemW-1]}}, elem_a_i};
  assign cof_ext  = {{(WW-CofW){cof_i[CofW-1]}}, cof_i};

  always_comb begin
    x   = '0;
    y   = '0;
    inv = 1'b1;
    unique case (ctrl_i.op)
      DpMul: begin
        x   = ctrl_i.tgt_c ? c_q : t_q;
        y   = a_q;
        inv = ctrl_i.neg ^ ctrl_i.last;
      end
      DpAbs: begin
        y = t_q;
      end
      DpSing: begin
        x = t_q;
        y = thr_sh;
      end
      DpNeg: begin
        y = c_q;
      end
      DpDiv: begin
        x = c_q;
        y = a_q;
      end
      default: begin
        inv = 1'b1;
      end
    endcase
  end

  assign sum     = x + (y ^ {WW{inv}}) + {{(WW-1){1'b0}}, inv};
  assign sum_neg = sum[WW-1];

  assign stat_o.sing = (t_q == '0) | sum_neg;
  assign stat_o.big  = ~sum_neg;

  always_comb begin
    unique case (ctrl_i.a_sel)
      ASelTacc: a_ld = t_q;
      ASelCof:  a_ld = cof_ext;
      default:  a_ld = elem_ext;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      DpLdMul: begin
        a_q <= a_ld;
        b_q <= elem_b_i;
        if (ctrl_i.clr) begin
          if (ctrl_i.tgt_c) begin
            c_q <= '0;
          end else begin
            t_q <= '0;
          end
        end
      end
      DpMul: begin
        if (b_q[0]) begin
          if (ctrl_i.tgt_c) begin
            c_q <= sum;
          end else begin
            t_q <= sum;
          end
        end
        a_q <= a_q << 1;
        b_q <= b_q >> 1;
      end
      DpAbs: begin
        det_neg_q <= t_q[WW-1];
        if (t_q[WW-1]) begin
          t_q <= sum;
        end
      end
      DpLdDiv: begin
        c_q       <= cof_ext << (2 * FRAC_BITS);
        num_neg_q <= cof_i[CofW-1];
        a_q       <= t_q << ElemW;
        q_q       <= '0;
      end
      DpNeg: begin
        if (num_neg_q) begin
          c_q <= sum;
        end
      end
      DpDiv: begin
        // The first compare tests for a quotient of 2^32 or more.
        if (ctrl_i.first) begin
          big_q <= ~sum_neg;
        end else begin
          if (!sum_neg) begin
            c_q <= sum;
          end
          q_q <= {q_q[ElemW-2:0], ~sum_neg};
        end
        a_q <= a_q >> 1;
      end
      default: begin
        big_q <= big_q;
      end
    endcase
  end

  assign neg   = num_neg_q ^ det_neg_q;
  assign cof_o = c_q[CofW-1:0];

  always_comb begin
    sat_o   = 1'b0;
    value_o = q_q;
    if (big_q) begin
      sat_o   = 1'b1;
      value_o = neg ? QMin : QMax;
    end else if (neg) begin
      if (q_q > QMin) begin
        sat_o   = 1'b1;
        value_o = QMin;
      end else begin
        value_o = ~q_q + 32'd1;
      end
    end else if (q_q[ElemW-1]) begin
      sat_o   = 1'b1;
      value_o = QMax;
    end
  end

endmodule

FILE: hw/rtl/matrix_inverse_4x4.sv
// One shared wide adder does all the arithmetic: 148 radix-2 multiplies and
// 16 restoring divides per matrix. A new matrix is taken only once the last
// result of the previous one has gone into the output register. Reset (async,
// active low) clears the load count, the sequencer and the output valid; the
// threshold resets to 1.
module matrix_inverse_4x4 import mi4_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] element
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] value, [35:32] position, rest zero
  output logic [1:0]  m_axis_tuser,   // [0] singular, [1] saturated
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [30:0] cfg_wdata_i
);

  typedef enum logic [12:0] {
    SLoad   = 13'b0000000000001,
    SFetch  = 13'b0000000000010,
    SLdOp   = 13'b0000000000100,
    SMul    = 13'b0000000001000,
    SCwr    = 13'b0000000010000,
    SAbs    = 13'b0000000100000,
    SSing   = 13'b0000001000000,
    SDFetch = 13'b0000010000000,
    SDLd    = 13'b0000100000000,
    SDNeg   = 13'b0001000000000,
    SDCmp   = 13'b0010000000000,
    SDStep  = 13'b0100000000000,
    SOut    = 13'b1000000000000
  } state_e;

  state_e      state_q, state_d;
  logic [3:0]  load_cnt_q, ci_q, ci_d;
  logic [1:0]  term_q, term_d, sub_q, sub_d;
  logic [4:0]  bit_q, bit_d;
  logic        det_ph_q, det_ph_d, sing_q, sing_d;
  logic [30:0] thr_q;

  logic             out_valid_q, out_sing_q, out_sat_q, out_last_q;
  logic [31:0]      out_value_q;
  logic [3:0]       out_pos_q;
  logic             load_out;

  logic             in_xfer;
  logic [3:0]       ra0, ra1, cof_ra;
  logic [ElemW-1:0] elem_a, elem_b, res_value;
  logic [CofW-1:0]  cof_rd, cof_wd;
  logic             res_sat;
  dp_ctrl_t         ctrl;
  dp_stat_t         stat;
  logic [1:0]       r, c, a_col, b_col;

  assign s_axis_tready = (state_q == SLoad);
  assign in_xfer       = s_axis_tvalid & s_axis_tready;

  assign r     = ci_q[3:2];
  assign c     = ci_q[1:0];
  assign a_col = (term_q == 2'd0) ? 2'd1 : 2'd0;
  assign b_col = (term_q == 2'd2) ? 2'd1 : 2'd2;

  always_comb begin
    ra0    = minor_addr(r, c, 2'd1, a_col);
    ra1    = minor_addr(r, c, 2'd2, b_col);
    cof_ra = {ci_q[1:0], ci_q[3:2]};
    if (det_ph_q) begin
      ra1    = ci_q;
      cof_ra = ci_q;
    end else if (sub_q == 2'd1) begin
      ra0 = minor_addr(r, c, 2'd1, b_col);
      ra1 = minor_addr(r, c, 2'd2, a_col);
    end else if (sub_q == 2'd2) begin
      ra1 = minor_addr(r, c, 2'd0, term_q);
    end
  end

  mi4_ram #(.Width(ElemW), .Depth(16)) u_mat_a (
    .clk_i   (clk_i),
    .we_i    (in_xfer),
    .waddr_i (load_cnt_q),
    .wdata_i (s_axis_tdata),
    .raddr_i (ra0),
    .rdata_o (elem_a)
  );

  mi4_ram #(.Width(ElemW), .Depth(16)) u_mat_b (
    .clk_i   (clk_i),
    .we_i    (in_xfer),
    .waddr_i (load_cnt_q),
    .wdata_i (s_axis_tdata),
    .raddr_i (ra1),
    .rdata_o (elem_b)
  );

  mi4_ram #(.Width(CofW), .Depth(16)) u_cof (
    .clk_i   (clk_i),
    .we_i    (state_q == SCwr),
    .waddr_i (ci_q),
    .wdata_i (cof_wd),
    .raddr_i (cof_ra),
    .rdata_o (cof_rd)
  );

  always_comb begin
    ctrl.op    = DpIdle;
    ctrl.a_sel = det_ph_q ? ASelCof : ((sub_q == 2'd2) ? ASelTacc : ASelElem);
    ctrl.tgt_c = !det_ph_q && (sub_q == 2'd2);
    ctrl.clr   = det_ph_q ? (ci_q == 4'd0) :
                 ((sub_q == 2'd0) || ((sub_q == 2'd2) && (term_q == 2'd0)));
    ctrl.neg   = 1'b0;
    ctrl.last  = &bit_q;
    ctrl.first = (state_q == SDCmp);
    if (!det_ph_q) begin
      if (sub_q == 2'd1) begin
        ctrl.neg = 1'b1;
      end else if (sub_q == 2'd2) begin
        ctrl.neg = r[0] ^ c[0] ^ (term_q == 2'd1);
      end
    end
    unique case (state_q)
      SLdOp:         ctrl.op = DpLdMul;
      SMul:          ctrl.op = DpMul;
      SAbs:          ctrl.op = DpAbs;
      SSing:         ctrl.op = DpSing;
      SDLd:          ctrl.op = DpLdDiv;
      SDNeg:         ctrl.op = DpNeg;
      SDCmp, SDStep: ctrl.op = DpDiv;
      default:       ctrl.op = DpIdle;
    endcase
  end

  mi4_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .thr_i    (thr_q),
    .elem_a_i (elem_a),
    .elem_b_i (elem_b),
    .cof_i    (cof_rd),
    .cof_o    (cof_wd),
    .stat_o   (stat),
    .value_o  (res_value),
    .sat_o    (res_sat)
  );

  assign load_out = (state_q == SOut) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d  = state_q;
    ci_d     = ci_q;
    term_d   = term_q;
    sub_d    = sub_q;
    bit_d    = bit_q;
    det_ph_d = det_ph_q;
    sing_d   = sing_q;
    unique case (state_q)
      SLoad: begin
        if (in_xfer && (load_cnt_q == 4'd15)) begin
          state_d  = SFetch;
          ci_d     = '0;
          term_d   = '0;
          sub_d    = '0;
          det_ph_d = 1'b0;
          sing_d   = 1'b0;
        end
      end
      SFetch: state_d = SLdOp;
      SLdOp: begin
        bit_d   = '0;
        state_d = SMul;
      end
      SMul: begin
        bit_d = bit_q + 5'd1;
        if (&bit_q) begin
          state_d = SFetch;
          if (det_ph_q) begin
            if (ci_q == 4'd3) begin
              state_d = SAbs;
            end else begin
              ci_d = ci_q + 4'd1;
            end
          end else if (sub_q != 2'd2) begin
            sub_d = sub_q + 2'd1;
          end else begin
            sub_d = '0;
            if (term_q != 2'd2) begin
              term_d = term_q + 2'd1;
            end else begin
              state_d = SCwr;
            end
          end
        end
      end
      SCwr: begin
        term_d  = '0;
        state_d = SFetch;
        ci_d    = ci_q + 4'd1;
        if (ci_q == 4'd15) begin
          det_ph_d = 1'b1;
        end
      end
      SAbs: state_d = SSing;
      SSing: begin
        det_ph_d = 1'b0;
        ci_d     = '0;
        if (stat.sing) begin
          sing_d  = 1'b1;
          state_d = SOut;
        end else begin
          state_d = SDFetch;
        end
      end
      SDFetch: state_d = SDLd;
      SDLd:    state_d = SDNeg;
      SDNeg:   state_d = SDCmp;
      SDCmp: begin
        bit_d   = '0;
        state_d = stat.big ? SOut : SDStep;
      end
      SDStep: begin
        bit_d = bit_q + 5'd1;
        if (&bit_q) begin
          state_d = SOut;
        end
      end
      SOut: begin
        if (load_out) begin
          if (sing_q || (ci_q == 4'd15)) begin
            state_d = SLoad;
          end else begin
            ci_d    = ci_q + 4'd1;
            state_d = SDFetch;
          end
        end
      end
      default: state_d = SLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SLoad;
      load_cnt_q  <= '0;
      ci_q        <= '0;
      term_q      <= '0;
      sub_q       <= '0;
      bit_q       <= '0;
      det_ph_q    <= 1'b0;
      sing_q      <= 1'b0;
      thr_q       <= 31'd1;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ci_q     <= ci_d;
      term_q   <= term_d;
      sub_q    <= sub_d;
      bit_q    <= bit_d;
      det_ph_q <= det_ph_d;
      sing_q   <= sing_d;
      if (in_xfer) begin
        load_cnt_q <= load_cnt_q + 4'd1;
      end
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_value_q <= sing_q ? '0 : res_value;
      out_pos_q   <= sing_q ? '0 : ci_q;
      out_sat_q   <= sing_q ? 1'b0 : res_sat;
      out_sing_q  <= sing_q;
      out_last_q  <= sing_q || (ci_q == 4'd15);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_pos_q, out_value_q};
  assign m_axis_tuser  = {out_sat_q, out_sing_q};
  assign m_axis_tlast  = out_last_q;

endmodule

FILE: hw/rtl/mi4_checker.sv
// Port-level checks on the result stream of the matrix inverse block.
// Bound to matrix_inverse_4x4; depends on nothing else.
module mi4_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast,
  input logic        cfg_we_i,
  input logic [30:0] cfg_wdata_i
);

  // A singular result is a lone, zero, unsaturated last transfer.
  a_sing_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      m_axis_tlast && (m_axis_tdata == 40'd0) && !m_axis_tuser[1])
    else $error("singular result malformed");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |->
      (m_axis_tdata[31:0] == 32'h7FFF_FFFF) || (m_axis_tdata[31:0] == 32'h8000_0000))
    else $error("saturated value not at a range limit");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast && !m_axis_tuser[0] |-> (m_axis_tdata[35:32] == 4'hF))
    else $error("last inverse element not at position 15");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[39:36] == 4'h0))
    else $error("tdata padding not zero");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

endmodule

bind matrix_inverse_4x4 mi4_checker u_mi4_checker (.*);
